// ===== hw/rtl/bnsm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bnsm_pkg
// Shared types and constants of the box suppression and score merge block.
// ----------------------------------------------------------------------------
package bnsm_pkg;

   localparam int COORD_W = 16;
   localparam int SIZE_W  = 12;
   localparam int SCORE_W = 32;
   localparam int PCT_W   = 7;
   localparam int GEOM_W  = 2 * COORD_W + 2 * SIZE_W;
   localparam int AREA_W  = 2 * SIZE_W;

   localparam logic [PCT_W-1:0] PCT_RESET = 7'd50;
   localparam logic [PCT_W-1:0] PCT_SCALE = 7'd100;

   // commands from the controller to the datapath
   typedef struct packed {
      logic load;
      logic sort_init;
      logic scan_init;
      logic scan_rd;
      logic scan_cmp;
      logic sort_store;
      logic sweep_init;
      logic a_rd_order;
      logic a_rd_box;
      logic a_load;
      logic skip_i;
      logic b_rd_order;
      logic b_rd_box;
      logic b_geo;
      logic b_area;
      logic b_uni;
      logic b_thr;
      logic b_cmp;
      logic skip_k;
      logic kept;
      logic finish;
   } cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic scan_done;
      logic sort_done;
      logic i_done;
      logic k_done;
      logic supp_i;
      logic supp_k;
   } status_type;

endpackage

// ===== hw/rtl/box_nms_score_merge.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_nms_score_merge
// Greedy box suppression with saturating score merge over one set of boxes.
// ----------------------------------------------------------------------------
// Usage:
//   Drive one box on the req_ ports and pulse start while busy is low; the box
//   is taken in that cycle. Boxes load at one per cycle. A box with
//   req_set_end high closes the set; busy then stays high while the set is
//   ordered by score (selection sort, one score memory read at a time) and
//   swept one box pair at a time through the single read port of the box
//   memories. Each kept box appears on the rsp_ ports for one cycle with
//   rsp_strobe high; rsp_result_end marks the last one of the set and
//   rsp_boxes_dropped flags a set that exceeded MAX_BOXES. The receiver
//   always takes a result in its strobe cycle. Boxes beyond MAX_BOXES are
//   dropped. The csr_ channel writes overlap_percent, always ready; write it
//   only while busy is low. Reset returns to idle with an empty set and
//   overlap_percent at 50; the box memories need no clearing pass.
// ----------------------------------------------------------------------------
module box_nms_score_merge #(
   parameter int MAX_BOXES = 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic signed [bnsm_pkg::COORD_W-1:0]  req_box_x,
   input  logic signed [bnsm_pkg::COORD_W-1:0]  req_box_y,
   input  logic [bnsm_pkg::SIZE_W-1:0]          req_box_width,
   input  logic [bnsm_pkg::SIZE_W-1:0]          req_box_height,
   input  logic signed [bnsm_pkg::SCORE_W-1:0]  req_box_score,
   input  logic                                 req_set_end,
   output logic                                 rsp_strobe,
   output logic signed [bnsm_pkg::COORD_W-1:0]  rsp_kept_x,
   output logic signed [bnsm_pkg::COORD_W-1:0]  rsp_kept_y,
   output logic [bnsm_pkg::SIZE_W-1:0]          rsp_kept_width,
   output logic [bnsm_pkg::SIZE_W-1:0]          rsp_kept_height,
   output logic signed [bnsm_pkg::SCORE_W-1:0]  rsp_merged_score,
   output logic                                 rsp_result_end,
   output logic                                 rsp_boxes_dropped,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [bnsm_pkg::PCT_W-1:0]           csr_data
);

   bnsm_pkg::cmd_type    cmd;
   bnsm_pkg::status_type stat;

   assign csr_ready = 1'b1;

   bnsm_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .set_end(req_set_end),
      .stat(stat), .cmd(cmd), .busy(busy)
   );

   bnsm_dpath #(.MAX_BOXES(MAX_BOXES)) u_dpath (
      .clock(clock), .reset(reset), .cmd(cmd), .stat(stat),
      .csr_valid(csr_valid), .csr_data(csr_data),
      .req_box_x(req_box_x), .req_box_y(req_box_y),
      .req_box_width(req_box_width), .req_box_height(req_box_height),
      .req_box_score(req_box_score),
      .rsp_strobe(rsp_strobe), .rsp_kept_x(rsp_kept_x), .rsp_kept_y(rsp_kept_y),
      .rsp_kept_width(rsp_kept_width), .rsp_kept_height(rsp_kept_height),
      .rsp_merged_score(rsp_merged_score), .rsp_result_end(rsp_result_end),
      .rsp_boxes_dropped(rsp_boxes_dropped)
   );

endmodule

// ===== hw/rtl/bnsm_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bnsm_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module bnsm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/bnsm_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bnsm_ctrl
// Sequencer for load, selection sort and greedy suppression sweep.
// ----------------------------------------------------------------------------
module bnsm_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                set_end,
   input  bnsm_pkg::status_type stat,
   output bnsm_pkg::cmd_type    cmd,
   output logic                busy
);

   typedef enum logic [4:0] {
      ST_IDLE, ST_SORT_CHK, ST_SCAN_RD, ST_SCAN_CMP, ST_SORT_STORE,
      ST_SWEEP_INIT, ST_A_CHK, ST_A_BOX, ST_A_LOAD,
      ST_B_CHK, ST_B_BOX, ST_B_LOAD, ST_B_AREA, ST_B_UNI, ST_B_THR, ST_B_CMP,
      ST_KEPT, ST_FINISH
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            cmd.sort_init = 1'b1;
            if (start) begin
               cmd.load = 1'b1;
               if (set_end) begin
                  state_in = ST_SORT_CHK;
               end
            end
         end
         ST_SORT_CHK: begin
            if (stat.sort_done) begin
               state_in = ST_SWEEP_INIT;
            end else begin
               cmd.scan_init = 1'b1;
               state_in      = ST_SCAN_RD;
            end
         end
         ST_SCAN_RD: begin
            if (stat.scan_done) begin
               state_in = ST_SORT_STORE;
            end else begin
               cmd.scan_rd = 1'b1;
               state_in    = ST_SCAN_CMP;
            end
         end
         ST_SCAN_CMP: begin
            cmd.scan_cmp = 1'b1;
            state_in     = ST_SCAN_RD;
         end
         ST_SORT_STORE: begin
            cmd.sort_store = 1'b1;
            state_in       = ST_SORT_CHK;
         end
         ST_SWEEP_INIT: begin
            cmd.sweep_init = 1'b1;
            state_in       = ST_A_CHK;
         end
         ST_A_CHK: begin
            if (stat.i_done) begin
               state_in = ST_FINISH;
            end else if (stat.supp_i) begin
               cmd.skip_i = 1'b1;
            end else begin
               cmd.a_rd_order = 1'b1;
               state_in       = ST_A_BOX;
            end
         end
         ST_A_BOX: begin
            cmd.a_rd_box = 1'b1;
            state_in     = ST_A_LOAD;
         end
         ST_A_LOAD: begin
            cmd.a_load = 1'b1;
            state_in   = ST_B_CHK;
         end
         ST_B_CHK: begin
            if (stat.k_done) begin
               state_in = ST_KEPT;
            end else if (stat.supp_k) begin
               cmd.skip_k = 1'b1;
            end else begin
               cmd.b_rd_order = 1'b1;
               state_in       = ST_B_BOX;
            end
         end
         ST_B_BOX: begin
            cmd.b_rd_box = 1'b1;
            state_in     = ST_B_LOAD;
         end
         ST_B_LOAD: begin
            cmd.b_geo = 1'b1;
            state_in  = ST_B_AREA;
         end
         ST_B_AREA: begin
            cmd.b_area = 1'b1;
            state_in   = ST_B_UNI;
         end
         ST_B_UNI: begin
            cmd.b_uni = 1'b1;
            state_in  = ST_B_THR;
         end
         ST_B_THR: begin
            cmd.b_thr = 1'b1;
            state_in  = ST_B_CMP;
         end
         ST_B_CMP: begin
            cmd.b_cmp = 1'b1;
            state_in  = ST_B_CHK;
         end
         ST_KEPT: begin
            cmd.kept = 1'b1;
            state_in = ST_A_CHK;
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

// ===== hw/rtl/bnsm_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bnsm_dpath
// Box stores, sort order, suppression mask, overlap arithmetic and results.
// ----------------------------------------------------------------------------
module bnsm_dpath #(
   parameter int MAX_BOXES = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  bnsm_pkg::cmd_type                 cmd,
   output bnsm_pkg::status_type              stat,
   input  logic                              csr_valid,
   input  logic [bnsm_pkg::PCT_W-1:0]        csr_data,
   input  logic signed [bnsm_pkg::COORD_W-1:0] req_box_x,
   input  logic signed [bnsm_pkg::COORD_W-1:0] req_box_y,
   input  logic [bnsm_pkg::SIZE_W-1:0]       req_box_width,
   input  logic [bnsm_pkg::SIZE_W-1:0]       req_box_height,
   input  logic signed [bnsm_pkg::SCORE_W-1:0] req_box_score,
   output logic                              rsp_strobe,
   output logic signed [bnsm_pkg::COORD_W-1:0] rsp_kept_x,
   output logic signed [bnsm_pkg::COORD_W-1:0] rsp_kept_y,
   output logic [bnsm_pkg::SIZE_W-1:0]       rsp_kept_width,
   output logic [bnsm_pkg::SIZE_W-1:0]       rsp_kept_height,
   output logic signed [bnsm_pkg::SCORE_W-1:0] rsp_merged_score,
   output logic                              rsp_result_end,
   output logic                              rsp_boxes_dropped
);

   localparam int IDX_W = $clog2(MAX_BOXES);
   localparam int CNT_W = $clog2(MAX_BOXES + 1);
   localparam int GW    = bnsm_pkg::GEOM_W;
   localparam int SW    = bnsm_pkg::SCORE_W;
   localparam int AW    = bnsm_pkg::AREA_W;
   localparam int PW    = bnsm_pkg::PCT_W;

   // set bookkeeping
   logic [CNT_W-1:0] count_ff, count_in;
   logic             ovf_ff, ovf_in;
   logic [PW-1:0]    pct_ff, pct_in;
   logic [CNT_W-1:0] p_ff, p_in, j_ff, j_in, i_ff, i_in, k_ff, k_in;
   logic [IDX_W-1:0] jd_ff, jd_in;
   logic [MAX_BOXES-1:0] sel_ff, sel_in, supp_ff, supp_in;
   logic             best_valid_ff, best_valid_in;
   logic [IDX_W-1:0] best_idx_ff, best_idx_in;
   logic signed [SW-1:0] best_score_ff, best_score_in;

   // kept box
   logic signed [15:0] ax_ff, ax_in, ay_ff, ay_in;
   logic [11:0]        aw_ff, aw_in, ah_ff, ah_in;
   logic [AW-1:0]      a_area_ff, a_area_in;
   logic signed [SW-1:0] merged_ff, merged_in;

   // candidate pipeline
   logic signed [18:0] iw_ff, iw_in, ih_ff, ih_in;
   logic [11:0]        bw_ff, bw_in, bh_ff, bh_in;
   logic signed [SW-1:0] bscore_ff, bscore_in;
   logic               ovl_ff, ovl_in;
   logic [AW-1:0]      inter_ff, inter_in, b_area_ff, b_area_in;
   logic [AW+1:0]      uni_ff, uni_in;
   logic [AW+6:0]      lhs_ff, lhs_in;
   logic [AW+PW+1:0]   prod_ff, prod_in;

   // pending result and output
   logic               pend_valid_ff, pend_valid_in;
   logic [GW-1:0]      pend_geom_ff, pend_geom_in;
   logic signed [SW-1:0] pend_score_ff, pend_score_in;
   logic               out_strobe_ff, out_strobe_in, out_end_ff, out_end_in;
   logic               out_drop_ff, out_drop_in;
   logic [GW-1:0]      out_geom_ff, out_geom_in;
   logic signed [SW-1:0] out_score_ff, out_score_in;

   // memories
   logic             box_we, ord_we;
   logic [IDX_W-1:0] box_waddr, box_raddr, ord_raddr;
   logic [GW-1:0]    geom_wdata, geom_rdata;
   logic [SW-1:0]    score_rdata;
   logic [IDX_W-1:0] ord_rdata;

   // combinational helpers
   logic signed [17:0] ax1, ax2, ay1, ay2, bx1, bx2, by1, by2;
   logic signed [17:0] ix1, ix2, iy1, iy2;
   logic signed [SW:0] sum;
   logic signed [AW+1:0] uni_raw;

   assign geom_wdata = {req_box_x, req_box_y, req_box_width, req_box_height};
   assign box_we     = cmd.load && (count_ff < CNT_W'(MAX_BOXES));
   assign box_waddr  = count_ff[IDX_W-1:0];
   assign box_raddr  = cmd.scan_rd ? j_ff[IDX_W-1:0] : ord_rdata;
   assign ord_we     = cmd.sort_store;
   assign ord_raddr  = cmd.a_rd_order ? i_ff[IDX_W-1:0] : k_ff[IDX_W-1:0];

   bnsm_ram #(.WIDTH(GW), .DEPTH(MAX_BOXES)) u_geom_ram (
      .clock(clock), .wr_en(box_we), .wr_addr(box_waddr), .wr_data(geom_wdata),
      .rd_addr(box_raddr), .rd_data(geom_rdata)
   );

   bnsm_ram #(.WIDTH(SW), .DEPTH(MAX_BOXES)) u_score_ram (
      .clock(clock), .wr_en(box_we), .wr_addr(box_waddr), .wr_data(req_box_score),
      .rd_addr(box_raddr), .rd_data(score_rdata)
   );

   bnsm_ram #(.WIDTH(IDX_W), .DEPTH(MAX_BOXES)) u_order_ram (
      .clock(clock), .wr_en(ord_we), .wr_addr(p_ff[IDX_W-1:0]), .wr_data(best_idx_ff),
      .rd_addr(ord_raddr), .rd_data(ord_rdata)
   );

   always_comb begin
      ax1 = {{2{ax_ff[15]}}, ax_ff};
      ay1 = {{2{ay_ff[15]}}, ay_ff};
      ax2 = ax1 + $signed({6'd0, aw_ff}) - 18'sd1;
      ay2 = ay1 + $signed({6'd0, ah_ff}) - 18'sd1;
      bx1 = {{2{geom_rdata[55]}}, geom_rdata[55:40]};
      by1 = {{2{geom_rdata[39]}}, geom_rdata[39:24]};
      bx2 = bx1 + $signed({6'd0, geom_rdata[23:12]}) - 18'sd1;
      by2 = by1 + $signed({6'd0, geom_rdata[11:0]}) - 18'sd1;
      ix1 = (ax1 > bx1) ? ax1 : bx1;
      iy1 = (ay1 > by1) ? ay1 : by1;
      ix2 = (ax2 < bx2) ? ax2 : bx2;
      iy2 = (ay2 < by2) ? ay2 : by2;
      sum = {merged_ff[SW-1], merged_ff} + {bscore_ff[SW-1], bscore_ff};
      uni_raw = $signed({2'b00, a_area_ff}) + $signed({2'b00, b_area_ff})
              - $signed({2'b00, inter_ff});
   end

   always_comb begin
      count_in      = count_ff;
      ovf_in        = ovf_ff;
      pct_in        = csr_valid ? csr_data : pct_ff;
      p_in          = cmd.sort_init ? '0 : p_ff;
      j_in          = j_ff;
      i_in          = i_ff;
      k_in          = k_ff;
      jd_in         = jd_ff;
      sel_in        = sel_ff;
      supp_in       = supp_ff;
      best_valid_in = best_valid_ff;
      best_idx_in   = best_idx_ff;
      best_score_in = best_score_ff;
      ax_in         = ax_ff;
      ay_in         = ay_ff;
      aw_in         = aw_ff;
      ah_in         = ah_ff;
      a_area_in     = a_area_ff;
      merged_in     = merged_ff;
      iw_in         = iw_ff;
      ih_in         = ih_ff;
      bw_in         = bw_ff;
      bh_in         = bh_ff;
      bscore_in     = bscore_ff;
      ovl_in        = ovl_ff;
      inter_in      = inter_ff;
      b_area_in     = b_area_ff;
      uni_in        = uni_ff;
      lhs_in        = lhs_ff;
      prod_in       = prod_ff;
      pend_valid_in = pend_valid_ff;
      pend_geom_in  = pend_geom_ff;
      pend_score_in = pend_score_ff;
      out_strobe_in = 1'b0;
      out_end_in    = out_end_ff;
      out_drop_in   = out_drop_ff;
      out_geom_in   = out_geom_ff;
      out_score_in  = out_score_ff;

      if (cmd.load) begin
         if (count_ff < CNT_W'(MAX_BOXES)) begin
            count_in = count_ff + CNT_W'(1);
         end else begin
            ovf_in = 1'b1;
         end
      end
      if (cmd.scan_init) begin
         j_in          = '0;
         best_valid_in = 1'b0;
      end
      if (cmd.scan_rd) begin
         jd_in = j_ff[IDX_W-1:0];
      end
      if (cmd.scan_cmp) begin
         j_in = j_ff + CNT_W'(1);
         if (!sel_ff[jd_ff] && (!best_valid_ff || ($signed(score_rdata) > best_score_ff)))
         begin
            best_valid_in = 1'b1;
            best_idx_in   = jd_ff;
            best_score_in = score_rdata;
         end
      end
      if (cmd.sort_store) begin
         sel_in[best_idx_ff] = 1'b1;
         p_in                = p_ff + CNT_W'(1);
      end
      if (cmd.sweep_init) begin
         i_in          = '0;
         supp_in       = '0;
         pend_valid_in = 1'b0;
      end
      if (cmd.skip_i) begin
         i_in = i_ff + CNT_W'(1);
      end
      if (cmd.a_load) begin
         ax_in     = geom_rdata[55:40];
         ay_in     = geom_rdata[39:24];
         aw_in     = geom_rdata[23:12];
         ah_in     = geom_rdata[11:0];
         a_area_in = geom_rdata[23:12] * geom_rdata[11:0];
         merged_in = score_rdata;
         k_in      = i_ff + CNT_W'(1);
      end
      if (cmd.skip_k) begin
         k_in = k_ff + CNT_W'(1);
      end
      if (cmd.b_geo) begin
         iw_in     = {ix2[17], ix2} - {ix1[17], ix1} + 19'sd1;
         ih_in     = {iy2[17], iy2} - {iy1[17], iy1} + 19'sd1;
         bw_in     = geom_rdata[23:12];
         bh_in     = geom_rdata[11:0];
         bscore_in = score_rdata;
      end
      if (cmd.b_area) begin
         ovl_in    = (iw_ff > 19'sd0) && (ih_ff > 19'sd0);
         inter_in  = iw_ff[11:0] * ih_ff[11:0];
         b_area_in = bw_ff * bh_ff;
      end
      if (cmd.b_uni) begin
         uni_in = uni_raw[AW+1] ? '0 : uni_raw;
      end
      if (cmd.b_thr) begin
         prod_in = {{PW{1'b0}}, uni_ff} * {{(AW+2){1'b0}}, pct_ff};
         lhs_in  = {7'd0, inter_ff} * {{AW{1'b0}}, bnsm_pkg::PCT_SCALE};
      end
      if (cmd.b_cmp) begin
         k_in = k_ff + CNT_W'(1);
         if (ovl_ff && ({2'b00, lhs_ff} > prod_ff)) begin
            supp_in[k_ff[IDX_W-1:0]] = 1'b1;
            if (sum[SW] != sum[SW-1]) begin
               merged_in = sum[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
            end else begin
               merged_in = sum[SW-1:0];
            end
         end
      end
      if (cmd.kept) begin
         if (pend_valid_ff) begin
            out_strobe_in = 1'b1;
            out_end_in    = 1'b0;
            out_drop_in   = ovf_ff;
            out_geom_in   = pend_geom_ff;
            out_score_in  = pend_score_ff;
         end
         pend_valid_in = 1'b1;
         pend_geom_in  = {ax_ff, ay_ff, aw_ff, ah_ff};
         pend_score_in = merged_ff;
         i_in          = i_ff + CNT_W'(1);
      end
      if (cmd.finish) begin
         if (pend_valid_ff) begin
            out_strobe_in = 1'b1;
            out_end_in    = 1'b1;
            out_drop_in   = ovf_ff;
            out_geom_in   = pend_geom_ff;
            out_score_in  = pend_score_ff;
         end
         pend_valid_in = 1'b0;
         count_in      = '0;
         ovf_in        = 1'b0;
         sel_in        = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         ovf_ff        <= 1'b0;
         pct_ff        <= bnsm_pkg::PCT_RESET;
         p_ff          <= '0;
         j_ff          <= '0;
         i_ff          <= '0;
         k_ff          <= '0;
         sel_ff        <= '0;
         supp_ff       <= '0;
         best_valid_ff <= 1'b0;
         pend_valid_ff <= 1'b0;
         out_strobe_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         ovf_ff        <= ovf_in;
         pct_ff        <= pct_in;
         p_ff          <= p_in;
         j_ff          <= j_in;
         i_ff          <= i_in;
         k_ff          <= k_in;
         sel_ff        <= sel_in;
         supp_ff       <= supp_in;
         best_valid_ff <= best_valid_in;
         pend_valid_ff <= pend_valid_in;
         out_strobe_ff <= out_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      jd_ff         <= jd_in;
      best_idx_ff   <= best_idx_in;
      best_score_ff <= best_score_in;
      ax_ff         <= ax_in;
      ay_ff         <= ay_in;
      aw_ff         <= aw_in;
      ah_ff         <= ah_in;
      a_area_ff     <= a_area_in;
      merged_ff     <= merged_in;
      iw_ff         <= iw_in;
      ih_ff         <= ih_in;
      bw_ff         <= bw_in;
      bh_ff         <= bh_in;
      bscore_ff     <= bscore_in;
      ovl_ff        <= ovl_in;
      inter_ff      <= inter_in;
      b_area_ff     <= b_area_in;
      uni_ff        <= uni_in;
      lhs_ff        <= lhs_in;
      prod_ff       <= prod_in;
      pend_geom_ff  <= pend_geom_in;
      pend_score_ff <= pend_score_in;
      out_end_ff    <= out_end_in;
      out_drop_ff   <= out_drop_in;
      out_geom_ff   <= out_geom_in;
      out_score_ff  <= out_score_in;
   end

   assign stat.scan_done = (j_ff == count_ff);
   assign stat.sort_done = (p_ff == count_ff);
   assign stat.i_done    = (i_ff == count_ff);
   assign stat.k_done    = (k_ff == count_ff);
   assign stat.supp_i    = supp_ff[i_ff[IDX_W-1:0]];
   assign stat.supp_k    = supp_ff[k_ff[IDX_W-1:0]];

   assign rsp_strobe        = out_strobe_ff;
   assign rsp_kept_x        = out_geom_ff[55:40];
   assign rsp_kept_y        = out_geom_ff[39:24];
   assign rsp_kept_width    = out_geom_ff[23:12];
   assign rsp_kept_height   = out_geom_ff[11:0];
   assign rsp_merged_score  = out_score_ff;
   assign rsp_result_end    = out_end_ff;
   assign rsp_boxes_dropped = out_drop_ff;

endmodule
